// File: design/fph_pkg.sv
package fph_pkg;

    // Default sizing of the hole table.
    localparam int NUM_HOLES_DEF = 8;
    localparam int SIZE_BITS_DEF = 16;

    // Widths of the request and response fields.
    localparam int CMD_W   = 1;
    localparam int SLOT_W  = 3;
    localparam int VALUE_W = 16;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 4;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

    // Fit policy codes; the unused code behaves as first fit.
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // Response status codes.
    localparam logic [STAT_W-1:0] STAT_LOADED    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ALLOCATED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_FIT    = 2'd2;

    // Configuration register indexes.
    localparam logic [0:0] CFG_FIT_POLICY   = 1'b0;
    localparam logic [0:0] CFG_HOLES_IN_USE = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SLOT_W-1:0]  hole_slot;
        logic [VALUE_W-1:0] size_value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  chosen_hole;
        logic [VALUE_W-1:0] space_left;
    } rsp_t;

    // Control from the sequencer to the picker.
    typedef struct packed {
        logic clear;
        logic valid;
    } pick_ctrl_t;

endpackage

// File: design/fit_policy_hole_allocator.sv
// Hole allocator with first, best and worst fit. A load request writes one hole
// size and goes from acceptance through the done state back to idle. An allocate
// request scans holes_in_use entries, capped at the table depth. The hole table
// sits in a single-port-read memory, so the scan reads one entry per cycle. Then
// the finish state writes the shrunken hole back when a hole fits, and the done
// state hands the response to the output register. One request is in work at a
// time. A finished response waits in the output register while the next request is
// accepted and processed. The handoff stalls, and the request takes longer, for as
// long as the previous response still sits unaccepted in the output register. Hole
// entries hold no defined value until loaded.
module fit_policy_hole_allocator
    import fph_pkg::*;
#(
    parameter int NUM_HOLES = NUM_HOLES_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    localparam int ADDR_W = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1,
    localparam int CNT_W  = $clog2(NUM_HOLES + 1),
    localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp_data,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_FINISH = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [1:0]           policy_reg;
    logic [CFG_W-1:0]     holes_reg;
    logic [CNT_W-1:0]     rd_cnt_reg;
    logic [CNT_W-1:0]     rd_cnt_next;
    logic                 cmp_valid_reg;
    logic                 cmp_valid_next;
    logic [ADDR_W-1:0]    cmp_idx_reg;
    logic [ADDR_W-1:0]    cmp_idx_next;
    logic [SIZE_BITS-1:0] req_size_reg;
    logic [SIZE_BITS-1:0] req_size_next;
    rsp_t                 res_reg;
    rsp_t                 res_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;

    logic [LIM_W-1:0]     lim_wide;
    logic [CNT_W-1:0]     limit;
    logic                 issue;
    logic                 accept;
    logic [SIZE_BITS-1:0] in_size;
    logic [SIZE_BITS-1:0] new_size;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [SIZE_BITS-1:0] ram_rdata;

    pick_ctrl_t           pick_ctrl;
    logic                 found;
    logic [ADDR_W-1:0]    pick_idx;
    logic [SIZE_BITS-1:0] best_size;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            holes_reg  <= CFG_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIT_POLICY:   policy_reg <= cfg_data[1:0];
                CFG_HOLES_IN_USE: holes_reg  <= cfg_data;
                default:          policy_reg <= policy_reg;
            endcase
        end
    end

    // Number of entries searched, saturated at the table depth.
    always_comb
    begin
        lim_wide = LIM_W'(holes_reg);
        if (lim_wide > LIM_W'(NUM_HOLES))
        begin
            limit = CNT_W'(NUM_HOLES);
        end
        else
        begin
            limit = CNT_W'(lim_wide);
        end
    end

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign in_size   = SIZE_BITS'(req_data.size_value);
    assign issue     = (rd_cnt_reg < limit);
    assign new_size  = best_size - req_size_reg;

    // Sequencer: scan reads, write-back and response staging.
    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        req_size_next  = req_size_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        pick_ctrl      = '{clear: 1'b0, valid: cmp_valid_reg};

        // The output register empties when the consumer takes the response.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_data.command == CMD_LOAD)
                    begin
                        // A load beyond the table writes nothing but still reports.
                        ram_we    = (32'(req_data.hole_slot) < NUM_HOLES);
                        ram_waddr = ADDR_W'(req_data.hole_slot);
                        ram_wdata = in_size;
                        res_next  = '{status:      STAT_LOADED,
                                      chosen_hole: req_data.hole_slot,
                                      space_left:  VALUE_W'(in_size)};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        req_size_next   = in_size;
                        rd_cnt_next     = '0;
                        pick_ctrl.clear = 1'b1;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // One read issued per cycle; its data is compared the next cycle.
                if (issue)
                begin
                    ram_re         = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_cnt_reg[ADDR_W-1:0];
                    rd_cnt_next    = rd_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (found)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pick_idx;
                    ram_wdata = new_size;
                    res_next  = '{status:      STAT_ALLOCATED,
                                  chosen_hole: SLOT_W'(pick_idx),
                                  space_left:  VALUE_W'(new_size)};
                end
                else
                begin
                    res_next = '{status:      STAT_NO_FIT,
                                 chosen_hole: '0,
                                 space_left:  '0};
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        req_size_reg <= req_size_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    // Hole size table.
    fph_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_HOLES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_cnt_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Policy compare and running pick.
    fph_picker #(
        .SIZE_BITS (SIZE_BITS),
        .ADDR_W    (ADDR_W)
    ) u_picker (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (pick_ctrl),
        .policy    (policy_reg),
        .idx       (cmp_idx_reg),
        .rdata     (ram_rdata),
        .req_size  (req_size_reg),
        .found     (found),
        .pick_idx  (pick_idx),
        .best_size (best_size)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

// File: design/fph_ram.sv
module fph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/fph_picker.sv
module fph_picker
    import fph_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int ADDR_W    = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pick_ctrl_t           ctrl,
    input  logic [1:0]           policy,
    input  logic [ADDR_W-1:0]    idx,
    input  logic [SIZE_BITS-1:0] rdata,
    input  logic [SIZE_BITS-1:0] req_size,
    output logic                 found,
    output logic [ADDR_W-1:0]    pick_idx,
    output logic [SIZE_BITS-1:0] best_size
);

    logic                 found_reg;
    logic                 found_next;
    logic [ADDR_W-1:0]    pick_reg;
    logic [ADDR_W-1:0]    pick_next;
    logic [SIZE_BITS-1:0] best_reg;
    logic [SIZE_BITS-1:0] best_next;
    logic                 fits;
    logic                 take;

    // A hole fits when it is at least as large as the request. Later fits replace
    // the pick only under best or worst fit, and only when strictly better, so
    // ties keep the lowest index.
    always_comb
    begin
        fits = (rdata >= req_size);
        take = 1'b0;
        if (fits)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (policy == POL_BEST)
            begin
                take = (rdata < best_reg);
            end
            else if (policy == POL_WORST)
            begin
                take = (rdata > best_reg);
            end
        end

        found_next = found_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctrl.valid && take)
        begin
            found_next = 1'b1;
            pick_next  = idx;
            best_next  = rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
        best_reg <= best_next;
    end

    assign found     = found_reg;
    assign pick_idx  = pick_reg;
    assign best_size = best_reg;

endmodule

// File: design/fph_checker.sv
module fph_checker
    import fph_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // A stalled response holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // Only one request is in work: the block is busy right after acceptance.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in work");

    // A failed allocation reports neither a hole nor a size.
    a_no_fit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == STAT_NO_FIT |->
            rsp_data.chosen_hole == '0 && rsp_data.space_left == '0)
        else $error("failed allocation carries a hole or size");

    // The status is always a defined code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.status == STAT_LOADED ||
            rsp_data.status == STAT_ALLOCATED || rsp_data.status == STAT_NO_FIT)
        else $error("undefined response status");

endmodule

bind fit_policy_hole_allocator fph_checker u_fph_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
